// ===== design/gsbp_pkg.sv =====
`default_nettype none

package gsbp_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned HB_CFG_W   = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HISTORY_BITS   = 1'b0,
    CFG_PREDICTOR_MODE = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_TRAIN   = 1'b1
  } cmd_t;

  typedef enum logic {
    MODE_STATIC = 1'b0,
    MODE_GSHARE = 1'b1
  } mode_t;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MIN         = 2'd0;
  localparam ctr_t CTR_MAX         = 2'd3;
  localparam ctr_t CTR_WEAK_NT     = 2'd1;
  localparam logic [HB_CFG_W-1:0] HB_RESET = 4'd13;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ===== design/gshare_branch_predictor_top.sv =====
`default_nettype none

// Gshare branch predictor with 2-bit saturating counters held in a single-port
// synchronous table of 2**MAX_HISTORY_BITS entries. After reset the table is
// swept to weakly-not-taken, one entry per cycle, and busy stays high until
// the sweep is done, so no request is taken before it ends; configuration
// writes are accepted during that sweep. A request is taken when start is
// high and busy is low; the table is read and the prediction appears on
// out_predict_taken with out_valid high for exactly one cycle in the next
// cycle, while a training request in gshare mode writes the updated counter
// back in that same cycle. Busy is high in the cycle that out_valid is high,
// so a new request is not taken until the current one is through.
// The receiver cannot stall: the result must be captured in the cycle that
// out_valid is high.
module gshare_branch_predictor_top #(
  parameter int unsigned MAX_HISTORY_BITS = 13
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [gsbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gsbp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_command,
  input  wire logic [31:0]                    in_branch_pc,
  input  wire logic                           in_outcome,
  output logic                                out_valid,
  output logic                                out_predict_taken
);
  import gsbp_pkg::*;

  localparam int unsigned IDX_W = MAX_HISTORY_BITS;
  localparam int unsigned HB_W  = $clog2(MAX_HISTORY_BITS + 1) > HB_CFG_W ?
                                  $clog2(MAX_HISTORY_BITS + 1) : HB_CFG_W;
  localparam logic [HB_W-1:0] HB_MAX = HB_W'(MAX_HISTORY_BITS);
  localparam logic [HB_W-1:0] HB_MIN = HB_W'(1);
  localparam int unsigned DEPTH = 1 << MAX_HISTORY_BITS;

  state_t                state_r, state_nxt;
  logic [HB_CFG_W-1:0]   hist_bits_r;
  mode_t                 mode_r;
  logic [IDX_W-1:0]      hist_r, hist_nxt;
  logic [IDX_W-1:0]      clr_idx_r;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  cmd_t                  cmd_r;
  logic                  outcome_r;

  ctr_t                  mem [DEPTH];
  ctr_t                  rd_data_r;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr;
  ctr_t                  mem_wdata;
  ctr_t                  ctr_upd;

  logic [HB_W-1:0]       hb_ext, hb_eff;
  logic [IDX_W-1:0]      mask;
  logic                  accept, train_wr;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    hb_ext = HB_W'(hist_bits_r);
    if (hb_ext < HB_MIN) begin
      hb_eff = HB_MIN;
    end else if (hb_ext > HB_MAX) begin
      hb_eff = HB_MAX;
    end else begin
      hb_eff = hb_ext;
    end
    for (int i = 0; i < IDX_W; i++) begin
      mask[i] = (int'(hb_eff) > i);
    end
    idx_nxt = (in_branch_pc[IDX_W-1:0] ^ hist_r) & mask;
  end

  always_comb begin
    ctr_upd = rd_data_r;
    if (outcome_r) begin
      if (rd_data_r != CTR_MAX) begin
        ctr_upd = rd_data_r + 2'd1;
      end
    end else begin
      if (rd_data_r != CTR_MIN) begin
        ctr_upd = rd_data_r - 2'd1;
      end
    end
  end

  assign train_wr = (state_r == ST_EXEC) && (cmd_r == CMD_TRAIN) && (mode_r == MODE_GSHARE);
  assign mem_re   = accept;
  assign mem_we   = (state_r == ST_CLEAR) || train_wr;
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_idx_r : idx_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? CTR_WEAK_NT : ctr_upd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[idx_nxt];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (&clr_idx_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    hist_nxt = hist_r;
    if (train_wr) begin
      hist_nxt = (hist_r << 1) | IDX_W'(outcome_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      hist_r      <= '0;
      hist_bits_r <= HB_RESET;
      mode_r      <= MODE_GSHARE;
    end else begin
      state_r <= state_nxt;
      hist_r  <= hist_nxt;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_HISTORY_BITS:   hist_bits_r <= cfg_data[HB_CFG_W-1:0];
          CFG_PREDICTOR_MODE: mode_r      <= mode_t'(cfg_data[0]);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r     <= idx_nxt;
      cmd_r     <= cmd_t'(in_command);
      outcome_r <= in_outcome;
    end
  end

  assign out_valid         = (state_r == ST_EXEC);
  assign out_predict_taken = (mode_r == MODE_GSHARE) ? rd_data_r[1] : 1'b1;

endmodule

`default_nettype wire
